[design/phist_pkg.sv]
// ----------------------------------------------------------------------------
// phist_pkg
// Types and constants shared by the pixel histogram block.
// ----------------------------------------------------------------------------
package phist_pkg;

  localparam int COUNT_BITS = 24;
  localparam int NUM_BINS   = 256;
  localparam int ADDR_W     = $clog2(NUM_BINS);
  localparam int PIX_W      = 8;
  localparam int POS_W      = 12;
  localparam int SHIFT_W    = 3;
  localparam int SIDE_W     = POS_W + 1;
  localparam int PROD_W     = SIDE_W + COUNT_BITS;
  localparam int BASE_SHIFT = 8;

  localparam logic [SHIFT_W-1:0]    SHIFT_RESET = SHIFT_W'(2);
  localparam logic [SHIFT_W-1:0]    MAX_SHIFT   = SHIFT_W'(4);
  localparam logic [SIDE_W-1:0]     BASE_SIDE   = SIDE_W'(256);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_PLOT  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef struct packed {
    func_t            func;
    logic [PIX_W-1:0] pixel_value;
    logic [PIX_W-1:0] bin_index;
    logic [POS_W-1:0] plot_row;
    logic [POS_W-1:0] plot_column;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] bin_count;
    logic [COUNT_BITS-1:0] max_count;
    logic                  plot_value;
  } out_item_t;

  typedef struct packed {
    logic              vld;
    func_t             func;
    logic [ADDR_W-1:0] addr;
    logic              outside;
    logic [SIDE_W-1:0] height;
  } s1_t;

  typedef struct packed {
    logic                  vld;
    func_t                 func;
    logic                  outside;
    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] peak;
    logic [PROD_W-1:0]     prod;
  } s2_t;

endpackage

[design/phist_bins.sv]
// ----------------------------------------------------------------------------
// phist_bins
// Bin memory with valid bits, write forwarding, running peak and the
// height-times-peak product for plot queries.
// ----------------------------------------------------------------------------
module phist_bins import phist_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  in_item_t           in_item,
  input  logic [SHIFT_W-1:0] shift_eff,
  output s2_t                s2
);

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [COUNT_BITS-1:0] mem_rd_r;
  logic [NUM_BINS-1:0]   bin_vld_r;
  logic [COUNT_BITS-1:0] peak_r;
  logic                  wb_vld_r;
  logic [ADDR_W-1:0]     wb_addr_r;
  logic [COUNT_BITS-1:0] wb_data_r;
  s1_t                   s1_r, s1_nxt;
  s2_t                   s2_r, s2_nxt;

  logic [SIDE_W-1:0]     side;
  logic [POS_W-1:0]      col_sh;
  logic [ADDR_W-1:0]     rd_addr;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  wr_en;
  logic                  clr;
  logic [PROD_W-1:0]     prod;

  always_comb begin
    side   = BASE_SIDE << shift_eff;
    col_sh = in_item.plot_column >> shift_eff;
    unique case (in_item.func)
      FUNC_ADD:   rd_addr = in_item.pixel_value;
      FUNC_READ:  rd_addr = in_item.bin_index;
      FUNC_PLOT:  rd_addr = col_sh[ADDR_W-1:0];
      FUNC_CLEAR: rd_addr = in_item.bin_index;
      default:    rd_addr = in_item.bin_index;
    endcase
    s1_nxt.vld     = acc;
    s1_nxt.func    = in_item.func;
    s1_nxt.addr    = rd_addr;
    s1_nxt.outside = ({1'b0, in_item.plot_row} >= side) ||
                     ({1'b0, in_item.plot_column} >= side);
    s1_nxt.height  = side - {1'b0, in_item.plot_row};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_r.addr] <= cnt_inc;
    end
    mem_rd_r <= mem[rd_addr];
  end

  always_comb begin
    wr_en = s1_r.vld && (s1_r.func == FUNC_ADD);
    clr   = s1_r.vld && (s1_r.func == FUNC_CLEAR);
    priority if (!bin_vld_r[s1_r.addr]) begin
      cur = '0;
    end else if (wb_vld_r && (wb_addr_r == s1_r.addr)) begin
      cur = wb_data_r;
    end else begin
      cur = mem_rd_r;
    end
    cnt_inc = (cur == COUNT_MAX) ? cur : cur + COUNT_BITS'(1);
    prod    = {{COUNT_BITS{1'b0}}, s1_r.height} * {{SIDE_W{1'b0}}, peak_r};
    s2_nxt.vld     = s1_r.vld && ((s1_r.func == FUNC_READ) || (s1_r.func == FUNC_PLOT));
    s2_nxt.func    = s1_r.func;
    s2_nxt.outside = s1_r.outside;
    s2_nxt.cnt     = cur;
    s2_nxt.peak    = peak_r;
    s2_nxt.prod    = prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r <= '0;
      peak_r    <= '0;
      wb_vld_r  <= 1'b0;
      wb_addr_r <= '0;
      wb_data_r <= '0;
      s2_r      <= '0;
    end else begin
      s2_r <= s2_nxt;
      if (clr) begin
        bin_vld_r <= '0;
        peak_r    <= '0;
        wb_vld_r  <= 1'b0;
      end else if (wr_en) begin
        bin_vld_r[s1_r.addr] <= 1'b1;
        wb_vld_r             <= 1'b1;
        wb_addr_r            <= s1_r.addr;
        wb_data_r            <= cnt_inc;
        if (cnt_inc > peak_r) begin
          peak_r <= cnt_inc;
        end
      end
    end
  end

  assign s2 = s2_r;

  a_peak_covers_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> peak_r >= $past(cnt_inc))
    else $error("peak below a written bin count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (peak_r == '0) && (bin_vld_r == '0) && !wb_vld_r)
    else $error("clear left state behind");

  a_result_func: assert property (@(posedge clk) disable iff (!rst_n)
    s2_r.vld |-> (s2_r.func == FUNC_READ) || (s2_r.func == FUNC_PLOT))
    else $error("result raised for an add or clear item");

endmodule

[design/phist_plot.sv]
// ----------------------------------------------------------------------------
// phist_plot
// Bar chart compare and result register.
// ----------------------------------------------------------------------------
module phist_plot import phist_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  s2_t                s2,
  input  logic [SHIFT_W-1:0] shift_eff,
  output logic               out_valid,
  output out_item_t          out_item
);

  logic              out_valid_r;
  out_item_t         out_item_r, out_item_nxt;
  logic [PROD_W-1:0] scaled;
  logic [3:0]        shamt;
  logic              dark;
  logic              is_plot;

  always_comb begin
    shamt   = {1'b0, shift_eff} + 4'(BASE_SHIFT);
    scaled  = {{SIDE_W{1'b0}}, s2.cnt} << shamt;
    dark    = s2.prod < scaled;
    is_plot = (s2.func == FUNC_PLOT);
    out_item_nxt.max_count = s2.peak;
    priority if (!is_plot) begin
      out_item_nxt.bin_count  = s2.cnt;
      out_item_nxt.plot_value = 1'b0;
    end else if (s2.outside) begin
      out_item_nxt.bin_count  = '0;
      out_item_nxt.plot_value = 1'b1;
    end else begin
      out_item_nxt.bin_count  = s2.cnt;
      out_item_nxt.plot_value = !dark;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[design/pixel_histogram_with_max_and_plot.sv]
// ----------------------------------------------------------------------------
// pixel_histogram_with_max_and_plot
// 256-bin grey-level histogram with running peak, bin read and bar chart query.
//
//   channel  ports                      handshake
//   input    start, busy, in_item       taken when start && !busy
//   result   out_valid, out_item        one-cycle strobe, always taken
//   config   cfg_we, cfg_wdata          written when cfg_we
//
// One item is taken every cycle; busy stays low.
// A read or plot item gives its result through the bin memory read, the
// product register and the result register, in that order.
// Add and clear items give no result.
// Reset clears all bins at once through per-bin valid bits; no sweep.
// ----------------------------------------------------------------------------
module pixel_histogram_with_max_and_plot import phist_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item,
  output logic               out_valid,
  output out_item_t          out_item,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata
);

  logic [SHIFT_W-1:0] shift_r;
  logic [SHIFT_W-1:0] shift_eff;
  logic               acc;
  s2_t                s2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_RESET;
    end else if (cfg_we) begin
      shift_r <= cfg_wdata;
    end
  end

  assign shift_eff = (shift_r > MAX_SHIFT) ? MAX_SHIFT : shift_r;
  assign busy      = 1'b0;
  assign acc       = start && !busy;

  phist_bins u_bins (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .in_item   (in_item),
    .shift_eff (shift_eff),
    .s2        (s2)
  );

  phist_plot u_plot (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2        (s2),
    .shift_eff (shift_eff),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[bench/phist_checker.sv]
// ----------------------------------------------------------------------------
// phist_checker
// Tracks the histogram, peak and chart scale from the accepted items and
// config writes, predicts each read and plot result, and compares every
// result strobe against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module phist_checker import phist_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  in_item_t           in_item,
  input  logic               out_valid,
  input  out_item_t          out_item,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [COUNT_BITS-1:0] hist [NUM_BINS];
  logic [COUNT_BITS-1:0] peak;
  logic [SHIFT_W-1:0]    scale;
  out_item_t             expected_q [$];

  function automatic out_item_t predict_read(in_item_t it);
    out_item_t r;
    r.bin_count  = hist[it.bin_index];
    r.max_count  = peak;
    r.plot_value = 1'b0;
    return r;
  endfunction

  function automatic out_item_t predict_plot(in_item_t it);
    out_item_t             r;
    logic [SHIFT_W-1:0]    s;
    logic [SIDE_W-1:0]     side;
    logic [COUNT_BITS-1:0] c;
    logic [47:0]           height;
    logic [47:0]           lhs;
    logic [47:0]           rhs;
    s = (scale > MAX_SHIFT) ? MAX_SHIFT : scale;
    side = BASE_SIDE << s;
    r.bin_count  = '0;
    r.max_count  = peak;
    r.plot_value = 1'b1;
    if (it.plot_row < side && it.plot_column < side) begin
      c = hist[ADDR_W'(it.plot_column >> s)];
      height = 48'(side - SIDE_W'(it.plot_row));
      lhs = height * 48'(peak);
      rhs = 48'(c) * 48'(side);
      r.bin_count  = c;
      r.plot_value = (lhs < rhs) ? 1'b0 : 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [COUNT_BITS-1:0] want,
                             logic [COUNT_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : track
    out_item_t want;
    if (!rst_n) begin
      foreach (hist[k]) hist[k] = '0;
      peak = '0;
      scale = SHIFT_RESET;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result with no item waiting: bin_count %0d max_count %0d plot_value %0d",
                 out_item.bin_count, out_item.max_count, out_item.plot_value);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("bin_count", want.bin_count, out_item.bin_count);
          check_field("max_count", want.max_count, out_item.max_count);
          check_field("plot_value", COUNT_BITS'(want.plot_value),
                      COUNT_BITS'(out_item.plot_value));
        end
      end
      if (start && !busy) begin
        case (in_item.func)
          FUNC_ADD: begin
            if (hist[in_item.pixel_value] != COUNT_MAX)
              hist[in_item.pixel_value] = hist[in_item.pixel_value] + COUNT_BITS'(1);
            if (hist[in_item.pixel_value] > peak) peak = hist[in_item.pixel_value];
          end
          FUNC_READ: expected_q.push_back(predict_read(in_item));
          FUNC_PLOT: expected_q.push_back(predict_plot(in_item));
          FUNC_CLEAR: begin
            foreach (hist[k]) hist[k] = '0;
            peak = '0;
          end
          default: ;
        endcase
      end
      if (cfg_we) scale = cfg_wdata;
    end
    pending <= expected_q.size();
  end

endmodule

[bench/tb_pixel_histogram_with_max_and_plot.sv]
// ----------------------------------------------------------------------------
// tb_pixel_histogram_with_max_and_plot
// Drives pixel, read, plot and clear items into the histogram block: a
// directed opening on empty and small histograms and chart edges, then
// random phases over every chart scale with idle bursts on the sender.
// The checker beside the block predicts and compares all results.
// ----------------------------------------------------------------------------
module tb_pixel_histogram_with_max_and_plot;
  import phist_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE      = 5;
  localparam int WATCH_LIMIT = 2000;
  localparam int PHASE_ITEMS = 140;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  in_item_t           in_item = '0;
  logic               out_valid;
  out_item_t          out_item;
  logic               cfg_we = 1'b0;
  logic [SHIFT_W-1:0] cfg_wdata = '0;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 gaps_on = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  pixel_histogram_with_max_and_plot dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  phist_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic in_item_t make(func_t f, logic [PIX_W-1:0] pix,
                                    logic [PIX_W-1:0] bidx, logic [POS_W-1:0] row,
                                    logic [POS_W-1:0] col);
    in_item_t it;
    it.func        = f;
    it.pixel_value = pix;
    it.bin_index   = bidx;
    it.plot_row    = row;
    it.plot_column = col;
    return it;
  endfunction

  task automatic send(in_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_scale(logic [SHIFT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [SHIFT_W-1:0] scales [8];
    logic [PIX_W-1:0]   hot [8];
    logic [PIX_W-1:0]   h;
    in_item_t           it;
    int                 eff;
    int                 side;
    int                 sel;

    scales = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd5, 3'd3, 3'd6, 3'd2};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(make(FUNC_PLOT, 8'd0, 8'd0, 12'd0, 12'd0));
    send(make(FUNC_READ, 8'd0, 8'd0, 12'd0, 12'd0));
    send(make(FUNC_READ, 8'd0, 8'd255, 12'd0, 12'd0));
    send(make(FUNC_ADD, 8'd255, 8'd0, 12'd0, 12'd0));
    send(make(FUNC_ADD, 8'd255, 8'd255, 12'd4095, 12'd4095));
    send(make(FUNC_ADD, 8'd0, 8'd0, 12'd0, 12'd0));
    send(make(FUNC_READ, 8'd0, 8'd255, 12'd0, 12'd0));
    send(make(FUNC_READ, 8'd255, 8'd0, 12'd4095, 12'd4095));
    send(make(FUNC_PLOT, 8'd0, 8'd0, 12'd1023, 12'd1023));
    send(make(FUNC_PLOT, 8'd0, 8'd0, 12'd0, 12'd1020));
    send(make(FUNC_PLOT, 8'd0, 8'd0, 12'd512, 12'd0));
    send(make(FUNC_PLOT, 8'd255, 8'd255, 12'd513, 12'd3));
    send(make(FUNC_PLOT, 8'd0, 8'd0, 12'd1024, 12'd0));
    send(make(FUNC_PLOT, 8'd0, 8'd0, 12'd0, 12'd1024));
    send(make(FUNC_PLOT, 8'd0, 8'd0, 12'd4095, 12'd4095));
    send(make(FUNC_READ, 8'd255, 8'd128, 12'd4095, 12'd4095));
    send(make(FUNC_CLEAR, 8'd255, 8'd255, 12'd4095, 12'd4095));
    send(make(FUNC_READ, 8'd0, 8'd255, 12'd0, 12'd0));
    send(make(FUNC_PLOT, 8'd0, 8'd0, 12'd1023, 12'd1023));

    foreach (scales[p]) begin
      settle();
      set_scale(scales[p]);
      eff = (scales[p] > MAX_SHIFT) ? int'(MAX_SHIFT) : int'(scales[p]);
      side = 256 << eff;
      gaps_on = (p != 7) && ($urandom_range(0, 3) != 0);
      foreach (hot[k]) hot[k] = PIX_W'($urandom);
      hot[0] = (p % 2 == 0) ? 8'd255 : 8'd0;
      repeat (PHASE_ITEMS) begin
        it.pixel_value = PIX_W'($urandom);
        it.bin_index   = PIX_W'($urandom);
        it.plot_row    = POS_W'($urandom);
        it.plot_column = POS_W'($urandom);
        h = hot[$urandom_range(0, 7)];
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          it.func = FUNC_ADD;
          if ($urandom_range(0, 2) != 0) it.pixel_value = h;
        end else if (sel < 70) begin
          it.func = FUNC_READ;
          if ($urandom_range(0, 1) != 0) it.bin_index = h;
        end else if (sel < 99) begin
          it.func = FUNC_PLOT;
          if ($urandom_range(0, 9) != 0) it.plot_row = POS_W'($urandom_range(0, side - 1));
          sel = $urandom_range(0, 9);
          if (sel < 5) begin
            it.plot_column = POS_W'((int'(h) << eff) + $urandom_range(0, (1 << eff) - 1));
          end else if (sel < 9) begin
            it.plot_column = POS_W'($urandom_range(0, side - 1));
          end
        end else begin
          it.func = FUNC_CLEAR;
        end
        send(it);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
